/* sv/tga_rle_pkg.sv */
// tga_rle_pkg: shared types and constants of the tga rle packet decoder
// no dependencies; used by the result interface and every module of the block
`default_nettype none

package tga_rle_pkg;

  // header bytes below this open a raw packet, the rest a run packet
  localparam int unsigned RawLimit = 128;
  localparam int unsigned RunBias = 127;

  // configuration port
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [DataW-1:0] data_t;

  // register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_BYTES_PER_PIXEL = 1'b0,
    REG_PIXEL_COUNT     = 1'b1
  } reg_idx_t;

  typedef logic [31:0] pixel_t;
  typedef logic [7:0]  count8_t;

  // queue entry between front and back
  typedef struct packed {
    logic    clear;     // start of image: clear back counters, no result
    pixel_t  pixel;
    count8_t rpt;       // repeat before clipping
  } item_t;

  localparam int unsigned QueueDepth = 2;

endpackage

`default_nettype wire

/* sv/tga_rle_if.sv */
// byte stream and result channel interfaces of the tga rle packet decoder
// depends on tga_rle_pkg
`default_nettype none

interface tga_rle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;

  modport source (output valid, output data_byte, output start_of_image, input ready);
  modport sink (input valid, input data_byte, input start_of_image, output ready);
endinterface

interface tga_rle_out_if;
  logic                      valid;
  logic                      ready;
  tga_rle_pkg::pixel_t       pixel_value;
  tga_rle_pkg::count8_t      repeat_count;
  logic                      image_done;
  logic                      status;

  modport source (output valid, output pixel_value, output repeat_count,
                  output image_done, output status, input ready);
  modport sink (input valid, input pixel_value, input repeat_count,
                input image_done, input status, output ready);
endinterface

`default_nettype wire

/* sv/tga_rle_packet_decoder.sv */
// Decodes a TGA run-length byte stream at one byte per clock, sustained: the
// header/byte parser, a two-entry queue and the pixel counter with its result
// register form a pipeline, so a byte is taken every cycle while the result side
// keeps up, and a result is held in a queue entry and then in the result register.
// Each finished pixel gives one result carrying the pixel and its repeat count
// (the consumer expands runs). If a packet runs past pixel_count the count is
// clipped, status is set, and later pixels give no result until the next start_of_image.
// Registers at 0x0 (bytes_per_pixel) and 0x4 (pixel_count); write them only
// while the stream is idle and all results are taken.
// depends on tga_rle_pkg, tga_rle_if and the front, queue and back modules
`default_nettype none

module tga_rle_packet_decoder #(
  parameter int unsigned MAX_BYTES_PER_PIXEL = 4,
  parameter int unsigned PIXEL_COUNT_BITS    = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  tga_rle_in_if.sink               in_ch,
  tga_rle_out_if.source            out_ch,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire tga_rle_pkg::addr_t  paddr,
  input  wire tga_rle_pkg::data_t  pwdata,
  output      tga_rle_pkg::data_t  prdata,
  output      logic                pready
);

  logic [2:0]                  bytes_per_pixel;
  logic [PIXEL_COUNT_BITS-1:0] pixel_count;
  tga_rle_pkg::reg_idx_t       reg_idx;
  logic                        cfg_write;

  logic               q_push, q_full, q_pop, q_not_empty;
  tga_rle_pkg::item_t q_item, q_head;

  assign pready    = 1'b1;
  assign reg_idx   = tga_rle_pkg::reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 3'd3;
      pixel_count     <= PIXEL_COUNT_BITS'(1);
    end else if (cfg_write) begin
      unique case (reg_idx)
        tga_rle_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= pwdata[2:0];
        tga_rle_pkg::REG_PIXEL_COUNT:     pixel_count <= pwdata[PIXEL_COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tga_rle_pkg::REG_BYTES_PER_PIXEL: prdata = tga_rle_pkg::data_t'(bytes_per_pixel);
      tga_rle_pkg::REG_PIXEL_COUNT:     prdata = tga_rle_pkg::data_t'(pixel_count);
      default:                          prdata = '0;
    endcase
  end

  tga_rle_front #(
    .MAX_BYTES_PER_PIXEL(MAX_BYTES_PER_PIXEL)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .data_byte      (in_ch.data_byte),
    .start_of_image (in_ch.start_of_image),
    .bytes_per_pixel(bytes_per_pixel),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_item)
  );

  tga_rle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(q_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  tga_rle_back #(
    .PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pixel_count (pixel_count),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .pixel_value (out_ch.pixel_value),
    .repeat_count(out_ch.repeat_count),
    .image_done  (out_ch.image_done),
    .status      (out_ch.status)
  );

endmodule

`default_nettype wire

/* sv/tga_rle_front.sv */
// tga_rle_front: parses headers and gathers pixel bytes, one byte per cycle while the queue is not full
// depends on tga_rle_pkg; pushes pixel and start-of-image entries to the queue
`default_nettype none

module tga_rle_front #(
  parameter int unsigned MAX_BYTES_PER_PIXEL = 4
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [7:0]          data_byte,
  input  wire logic                start_of_image,
  input  wire logic [2:0]          bytes_per_pixel,
  input  wire logic                q_full,
  output      logic                q_push,
  output      tga_rle_pkg::item_t  q_item
);

  localparam int unsigned AsmW = 8 * MAX_BYTES_PER_PIXEL;

  logic            expect_header, expect_header_next;
  logic            packet_is_run, packet_is_run_next;
  logic [7:0]      packet_pixels_left, packet_pixels_left_next;
  logic [1:0]      byte_in_pixel, byte_in_pixel_next;
  logic [AsmW-1:0] pixel_assembly, pixel_assembly_next;

  logic            accept;
  logic [2:0]      bpp;
  logic [AsmW-1:0] asm_merged;
  logic            pixel_done;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    bpp = bytes_per_pixel;
    if (bpp == 3'd0) begin
      bpp = 3'd1;
    end
    if (bpp > 3'(MAX_BYTES_PER_PIXEL)) begin
      bpp = 3'(MAX_BYTES_PER_PIXEL);
    end
  end

  always_comb begin
    asm_merged = pixel_assembly;
    for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
      if (byte_in_pixel == 2'(i)) begin
        asm_merged[8*i +: 8] = data_byte;
      end
    end
  end

  assign pixel_done = ({1'b0, byte_in_pixel} + 3'd1) >= bpp;

  always_comb begin
    expect_header_next      = expect_header;
    packet_is_run_next      = packet_is_run;
    packet_pixels_left_next = packet_pixels_left;
    byte_in_pixel_next      = byte_in_pixel;
    pixel_assembly_next     = pixel_assembly;
    q_push                  = 1'b0;
    q_item.clear            = start_of_image;
    q_item.pixel            = tga_rle_pkg::pixel_t'(asm_merged);
    q_item.rpt              = packet_is_run ? packet_pixels_left : 8'd1;
    if (accept) begin
      if (start_of_image || expect_header) begin
        // header byte; a start of image always lands here
        q_push              = start_of_image;
        expect_header_next  = 1'b0;
        byte_in_pixel_next  = '0;
        pixel_assembly_next = '0;
        if (data_byte < 8'(tga_rle_pkg::RawLimit)) begin
          packet_is_run_next      = 1'b0;
          packet_pixels_left_next = data_byte + 8'd1;
        end else begin
          packet_is_run_next      = 1'b1;
          packet_pixels_left_next = data_byte - 8'(tga_rle_pkg::RunBias);
        end
      end else if (!pixel_done) begin
        byte_in_pixel_next  = byte_in_pixel + 2'd1;
        pixel_assembly_next = asm_merged;
      end else begin
        q_push              = 1'b1;
        byte_in_pixel_next  = '0;
        pixel_assembly_next = '0;
        if (packet_is_run || packet_pixels_left <= 8'd1) begin
          packet_pixels_left_next = '0;
          expect_header_next      = 1'b1;
        end else begin
          packet_pixels_left_next = packet_pixels_left - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header      <= 1'b1;
      packet_is_run      <= 1'b0;
      packet_pixels_left <= '0;
      byte_in_pixel      <= '0;
      pixel_assembly     <= '0;
    end else begin
      expect_header      <= expect_header_next;
      packet_is_run      <= packet_is_run_next;
      packet_pixels_left <= packet_pixels_left_next;
      byte_in_pixel      <= byte_in_pixel_next;
      pixel_assembly     <= pixel_assembly_next;
    end
  end

endmodule

`default_nettype wire

/* sv/tga_rle_queue.sv */
// tga_rle_queue: two-entry queue between the front and the back
// depends on tga_rle_pkg for the entry type
`default_nettype none

module tga_rle_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire tga_rle_pkg::item_t  push_item,
  output      logic                full,
  input  wire logic                pop,
  output      logic                not_empty,
  output      tga_rle_pkg::item_t  head
);

  tga_rle_pkg::item_t entries [tga_rle_pkg::QueueDepth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'(tga_rle_pkg::QueueDepth);
  assign not_empty = count != 2'd0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue popped while empty");

  assert property (@(posedge clk) disable iff (rst) (full && !pop) |=> !$past(push))
    else $error("queue written while full");

endmodule

`default_nettype wire

/* sv/tga_rle_back.sv */
// tga_rle_back: counts emitted pixels, clips on overflow, drives the result register
// depends on tga_rle_pkg; takes entries from tga_rle_queue
`default_nettype none

module tga_rle_back #(
  parameter int unsigned PIXEL_COUNT_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [PIXEL_COUNT_BITS-1:0] pixel_count,
  input  wire logic                        q_not_empty,
  input  wire tga_rle_pkg::item_t          q_head,
  output      logic                        q_pop,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      tga_rle_pkg::pixel_t         pixel_value,
  output      tga_rle_pkg::count8_t        repeat_count,
  output      logic                        image_done,
  output      logic                        status
);

  localparam int unsigned CntW = PIXEL_COUNT_BITS;

  logic [CntW-1:0] pixels_emitted;
  logic            halted;

  logic [CntW-1:0]      remaining;
  logic [CntW-1:0]      rpt_wide;
  logic                 over;
  tga_rle_pkg::count8_t rpt_clip;
  logic                 done;
  logic                 emit;

  assign q_pop = q_not_empty && (!out_valid || out_ready);
  assign emit  = q_pop && !q_head.clear && !halted;

  assign remaining = (pixel_count > pixels_emitted) ? pixel_count - pixels_emitted : '0;
  assign rpt_wide  = CntW'(q_head.rpt);
  assign over      = rpt_wide > remaining;
  // when clipped, remaining is below the run length and fits eight bits
  assign rpt_clip  = over ? remaining[7:0] : q_head.rpt;
  assign done      = (rpt_clip != 8'd0) && (CntW'(rpt_clip) == remaining);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixels_emitted <= '0;
      halted         <= 1'b0;
    end else if (q_pop) begin
      if (q_head.clear) begin
        pixels_emitted <= '0;
        halted         <= 1'b0;
      end else if (!halted) begin
        pixels_emitted <= pixels_emitted + CntW'(rpt_clip);
        halted         <= over;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_value  <= q_head.pixel;
      repeat_count <= rpt_clip;
      image_done   <= done;
      status       <= over;
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid && image_done |-> repeat_count != 8'd0)
    else $error("image done with zero repeat");

  assert property (@(posedge clk) disable iff (rst) emit && over |=> halted)
    else $error("overflow did not halt");

  assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(pixel_value) && $stable(repeat_count))
    else $error("result changed while stalled");

endmodule

`default_nettype wire
